/* hdl/dme_pkg.sv */
// ----------------------------------------------------------------------------
// dme_pkg
// Shared types, constants and the control program for the delta modulation
// encoder: step codes, control word layout and the microcode table.
// ----------------------------------------------------------------------------
`default_nettype none

package dme_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int PCT_W    = 10;
  localparam int AMP_W    = 6;
  localparam int ACC_W    = 11;
  localparam int LVL_W    = 6;
  localparam int X_W      = 8;
  localparam int PROD_W   = 23;
  localparam int POS_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 2;
  localparam int CDATA_W  = 10;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_OVERSAMPLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE  = 2'd1;

  // register reset values and legal ranges
  localparam logic [PCT_W-1:0] PCT_RESET = 10'd100;
  localparam logic [PCT_W-1:0] PCT_MIN   = 10'd100;
  localparam logic [PCT_W-1:0] PCT_MAX   = 10'd1000;
  localparam logic [AMP_W-1:0] AMP_RESET = 6'd24;
  localparam logic [AMP_W-1:0] AMP_MIN   = 6'd2;
  localparam logic [AMP_W-1:0] AMP_MAX   = 6'd40;

  // rate accumulator
  localparam logic [ACC_W-1:0] ACC_RESET = 11'd99;
  localparam logic [ACC_W-1:0] ACC_UNIT  = 11'd100;

  // rounding of the scaled sample
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = 23'sd16384;
  localparam int ROUND_SHIFT = 15;

  // level saturation limits
  localparam logic signed [LVL_W-1:0] LVL_MAX = 6'sd31;
  localparam logic signed [LVL_W-1:0] LVL_MIN = -6'sd32;

  // sequencer steps
  typedef enum logic [1:0] {
    STEP_WAIT  = 2'd0,
    STEP_SCALE = 2'd1,
    STEP_ROUND = 2'd2,
    STEP_EMIT  = 2'd3
  } step_t;

  // jump conditions
  typedef enum logic [1:0] {
    COND_ALWAYS    = 2'd0,
    COND_IN_FIRE   = 2'd1,
    COND_EMIT_LAST = 2'd2
  } cond_t;

  // datapath controls driven by one control word
  typedef struct packed {
    logic ld_sample;
    logic do_mul;
    logic do_round;
    logic do_emit;
  } ctrl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic emit_fire;
    logic emit_last;
  } stat_t;

  // one microcode word: controls, jump condition and jump target
  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t target;
  } ucode_t;

  // control program, one word per step; a step repeats until its condition holds
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_WAIT: begin
        w.ctrl.ld_sample = 1'b1;
        w.cond           = COND_IN_FIRE;
        w.target         = STEP_SCALE;
      end
      STEP_SCALE: begin
        w.ctrl.do_mul = 1'b1;
        w.cond        = COND_ALWAYS;
        w.target      = STEP_ROUND;
      end
      STEP_ROUND: begin
        w.ctrl.do_round = 1'b1;
        w.cond          = COND_ALWAYS;
        w.target        = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.ctrl.do_emit = 1'b1;
        w.cond         = COND_EMIT_LAST;
        w.target       = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/dme_seq.sv */
// ----------------------------------------------------------------------------
// dme_seq
// Microcode sequencer: step counter, control table read and conditional jump.
// ----------------------------------------------------------------------------
`default_nettype none

module dme_seq (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  dme_pkg::stat_t  stat,
  output dme_pkg::ctrl_t  ctrl
);
  import dme_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t word;
  logic   in_fire;
  logic   cond_ok;

  // control word of the current step
  always_comb begin
    word     = ucode_rom(step_r);
    ctrl     = word.ctrl;
    in_stall = !word.ctrl.ld_sample;
    in_fire  = in_valid && word.ctrl.ld_sample;
  end

  // jump condition and next step
  always_comb begin
    case (word.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_IN_FIRE:   cond_ok = in_fire;
      COND_EMIT_LAST: cond_ok = stat.emit_fire && stat.emit_last;
      default:        cond_ok = 1'b0;
    endcase
    step_nxt = cond_ok ? word.target : step_r;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/dme_dp.sv */
// ----------------------------------------------------------------------------
// dme_dp
// Encoder datapath: configuration registers, sample scaling, rate
// accumulator, level tracker, bit packer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dme_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  dme_pkg::ctrl_t                        ctrl,
  output dme_pkg::stat_t                        stat,
  input  wire signed [dme_pkg::SAMPLE_W-1:0]    in_sample,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire        [dme_pkg::IDX_W-1:0]       cfg_index,
  input  wire        [dme_pkg::CDATA_W-1:0]     cfg_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  out_delta_bit,
  output logic       [7:0]                      out_decoded_level,
  output logic       [dme_pkg::BYTE_W-1:0]      out_code_byte,
  output logic                                  out_byte_ready,
  output logic                                  out_last
);
  import dme_pkg::*;

  logic        [PCT_W-1:0]    pct_r;
  logic        [AMP_W-1:0]    amp_r;
  logic        [PCT_W-1:0]    pct_wr;
  logic        [AMP_W-1:0]    amp_wr;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   rsum;
  logic signed [X_W-1:0]      x_r;

  logic        [ACC_W-1:0]    acc_r;
  logic        [ACC_W-1:0]    acc_sub;
  logic signed [LVL_W-1:0]    lvl_r;
  logic signed [LVL_W-1:0]    lvl_nxt;
  logic        [BYTE_W-1:0]   shift_r;
  logic        [BYTE_W-1:0]   shift_with;
  logic        [POS_W-1:0]    pos_r;
  logic                       up;
  logic                       ready_bit;
  logic                       emit_fire;
  logic                       emit_last;

  logic                       out_valid_r;
  logic                       dbit_r;
  logic        [7:0]          dlvl_r;
  logic        [BYTE_W-1:0]   cbyte_r;
  logic                       bready_r;
  logic                       last_r;

  assign cfg_ready = 1'b1;

  // saturate register writes to their legal ranges
  always_comb begin
    pct_wr = cfg_data[PCT_W-1:0];
    if (pct_wr < PCT_MIN) pct_wr = PCT_MIN;
    if (pct_wr > PCT_MAX) pct_wr = PCT_MAX;
    amp_wr = cfg_data[AMP_W-1:0];
    if (amp_wr < AMP_MIN) amp_wr = AMP_MIN;
    if (amp_wr > AMP_MAX) amp_wr = AMP_MAX;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
      amp_r <= AMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_OVERSAMPLE) pct_r <= pct_wr;
      if (cfg_index == REG_AMPLITUDE)  amp_r <= amp_wr;
    end
  end

  // scaling: multiply, then round and drop fifteen fraction bits
  assign prod_nxt = PROD_W'(sample_r * $signed({1'b0, amp_r}));
  assign rsum     = prod_r + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (ctrl.ld_sample) sample_r <= in_sample;
    if (ctrl.do_mul)    prod_r   <= prod_nxt;
    if (ctrl.do_round)  x_r      <= rsum[ROUND_SHIFT +: X_W];
  end

  // one delta bit: level step, packing and last flag
  always_comb begin
    emit_fire = ctrl.do_emit && (!out_valid_r || !out_stall);
    acc_sub   = acc_r - ACC_UNIT;
    emit_last = acc_sub < ACC_UNIT;
    up        = x_r >= $signed({{(X_W-LVL_W){lvl_r[LVL_W-1]}}, lvl_r});
    if (up) begin
      lvl_nxt = (lvl_r == LVL_MAX) ? LVL_MAX : lvl_r + 6'sd1;
    end else begin
      lvl_nxt = (lvl_r == LVL_MIN) ? LVL_MIN : lvl_r - 6'sd1;
    end
    shift_with = shift_r | (BYTE_W'(up) << pos_r);
    ready_bit  = pos_r == {POS_W{1'b1}};
  end

  assign stat.emit_fire = emit_fire;
  assign stat.emit_last = emit_last;

  // encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= ACC_RESET;
      lvl_r   <= '0;
      shift_r <= '0;
      pos_r   <= '0;
    end else if (ctrl.do_mul) begin
      acc_r <= acc_r + {1'b0, pct_r};
    end else if (emit_fire) begin
      acc_r   <= acc_sub;
      lvl_r   <= lvl_nxt;
      shift_r <= ready_bit ? '0 : shift_with;
      pos_r   <= pos_r + 3'd1;
    end
  end

  // output register, held while the far side stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // decoded level is level*4+128: shift left two and flip the top bit
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      dbit_r   <= up;
      dlvl_r   <= {~lvl_nxt[LVL_W-1], lvl_nxt[LVL_W-2:0], 2'b00};
      cbyte_r  <= shift_with;
      bready_r <= ready_bit;
      last_r   <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_delta_bit     = dbit_r;
  assign out_decoded_level = dlvl_r;
  assign out_code_byte     = cbyte_r;
  assign out_byte_ready    = bready_r;
  assign out_last          = last_r;

`ifndef SYNTH
  // accumulator holds less than one bit's worth between samples
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ld_sample |-> acc_r < ACC_UNIT)
    else $error("rate accumulator not drained between samples");

  // a bit is only sent with at least one bit's worth in the accumulator
  a_acc_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> acc_r >= ACC_UNIT)
    else $error("delta bit sent from an empty accumulator");

  // a completed byte restarts packing
  a_byte_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && ready_bit) |=> (pos_r == '0) && (shift_r == '0))
    else $error("packer not cleared after a full byte");

  // level moves by one step or sits at a limit
  a_lvl_step: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (lvl_r == $past(lvl_r) + 1) || (lvl_r == $past(lvl_r) - 1)
      || ((lvl_r == LVL_MAX) && ($past(lvl_r) == LVL_MAX))
      || ((lvl_r == LVL_MIN) && ($past(lvl_r) == LVL_MIN)))
    else $error("level step out of range");
`endif

endmodule

`default_nettype wire

/* hdl/delta_modulation_audio_encoder.sv */
// ----------------------------------------------------------------------------
// delta_modulation_audio_encoder
// One-bit delta modulation encoder: scales each sample, emits one to ten
// delta bits per sample and packs them into code bytes.
// ----------------------------------------------------------------------------
// flow: the wait step takes a sample, the scale and round steps register it,
//   then n = 1..10 bits are registered, one bit per cycle through the emit step
//   of the microcode sequencer, slower if out_stall; no sample is taken meanwhile
// reset: synchronous active-low rst_n returns registers to 100 / 24, the rate
//   accumulator to 99 and level, partial byte and bit position to zero
`default_nettype none

module delta_modulation_audio_encoder (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire signed [dme_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic                                out_delta_bit,
  output logic       [7:0]                    out_decoded_level,
  output logic       [dme_pkg::BYTE_W-1:0]    out_code_byte,
  output logic                                out_byte_ready,
  output logic                                out_last,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire        [dme_pkg::IDX_W-1:0]     cfg_index,
  input  wire        [dme_pkg::CDATA_W-1:0]   cfg_data
);
  import dme_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // microcode sequencer
  dme_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath
  dme_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .stat              (stat),
    .in_sample         (in_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_delta_bit     (out_delta_bit),
    .out_decoded_level (out_decoded_level),
    .out_code_byte     (out_code_byte),
    .out_byte_ready    (out_byte_ready),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

/* bench/delta_modulation_audio_encoder_test.sv */
// ----------------------------------------------------------------------------
// delta_modulation_audio_encoder_test
// Self-checking bench for the delta modulation encoder. A clocked driver sends
// samples from a queue in random bursts, a clocked monitor checks every delta
// bit result against a bit-accurate predictor of level, packing and rate.
// ----------------------------------------------------------------------------

module delta_modulation_audio_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dme_pkg::*;

  // indexes with no register behind them
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int  MAX_BITS     = 10;
  localparam int  REPORT_LIMIT = 10;
  localparam int  DRAIN_CYCLES = 30;
  localparam time RUN_LIMIT    = 3ms;

  // one delta bit as it leaves the block
  typedef struct packed {
    logic              delta_bit;
    logic [7:0]        decoded_level;
    logic [BYTE_W-1:0] code_byte;
    logic              byte_ready;
    logic              last;
  } bit_result_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample  = '0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic                       out_delta_bit;
  logic [7:0]                 out_decoded_level;
  logic [BYTE_W-1:0]          out_code_byte;
  logic                       out_byte_ready;
  logic                       out_last;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index  = '0;
  logic [CDATA_W-1:0]         cfg_data   = '0;

  // predictor state
  logic [PCT_W-1:0]           pct_reg    = PCT_RESET;
  logic [AMP_W-1:0]           amp_reg    = AMP_RESET;
  logic [ACC_W-1:0]           rate_acc   = ACC_RESET;
  logic signed [LVL_W-1:0]    level_reg  = '0;
  logic [BYTE_W-1:0]          packed_bits = '0;
  logic [POS_W-1:0]           bit_pos    = '0;

  logic signed [SAMPLE_W-1:0] sample_q [$];
  bit_result_t                expected_bits [$];

  int mismatch_count = 0;
  int samples_sent   = 0;
  int bits_checked   = 0;
  int reg_writes     = 0;
  int settings_used  = 0;

  // register values worth hitting: limits, just outside, masked wrap
  int unsigned pct_edges [10] = '{0, 99, 100, 101, 150, 250, 999, 1000, 1001, 1023};
  int unsigned amp_edges [10] = '{0, 1, 2, 3, 39, 40, 41, 63, 64, 1023};

  delta_modulation_audio_encoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_delta_bit     (out_delta_bit),
    .out_decoded_level (out_decoded_level),
    .out_code_byte     (out_code_byte),
    .out_byte_ready    (out_byte_ready),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // scale one sample and produce its delta bits, updating the predicted state
  function automatic void encode_sample(input logic signed [SAMPLE_W-1:0] s);
    bit_result_t burst [MAX_BITS];
    int target;
    int n;
    target = (int'(s) * int'(amp_reg) + int'(ROUND_BIAS)) >>> ROUND_SHIFT;
    n = 0;
    rate_acc = rate_acc + pct_reg;
    while (rate_acc >= ACC_UNIT && n < MAX_BITS) begin
      rate_acc = rate_acc - ACC_UNIT;
      burst[n] = '0;
      if (target >= int'(level_reg)) begin
        burst[n].delta_bit = 1'b1;
        if (level_reg != LVL_MAX) level_reg = level_reg + 6'sd1;
      end else begin
        if (level_reg != LVL_MIN) level_reg = level_reg - 6'sd1;
      end
      packed_bits = packed_bits | (BYTE_W'(burst[n].delta_bit) << bit_pos);
      burst[n].decoded_level = 8'(int'(level_reg) * 4 + 128);
      burst[n].code_byte     = packed_bits;
      burst[n].byte_ready    = (bit_pos == 3'd7);
      if (burst[n].byte_ready) packed_bits = '0;
      bit_pos = bit_pos + 1'b1;
      n++;
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_bits.push_back(burst[i]);
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR %0t: %s", $time, msg);
  endfunction

  // register write request, predictor follows the saturating write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    logic [AMP_W-1:0] amp_raw;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    amp_raw = data[AMP_W-1:0];
    case (idx)
      REG_OVERSAMPLE: begin
        pct_reg = (data < PCT_MIN) ? PCT_MIN : (data > PCT_MAX) ? PCT_MAX : data[PCT_W-1:0];
      end
      REG_AMPLITUDE: begin
        amp_reg = (amp_raw < AMP_MIN) ? AMP_MIN : (amp_raw > AMP_MAX) ? AMP_MAX : amp_raw;
      end
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  // wait until nothing is queued, offered or outstanding, then realign to the edge
  task automatic wait_idle();
    do @(negedge clk); while (sample_q.size() != 0 || in_valid || expected_bits.size() != 0);
    @(posedge clk);
  endtask

  task automatic queue_random_samples(input int count);
    logic signed [SAMPLE_W-1:0] smp;
    for (int i = 0; i < count; i++) begin
      smp = SAMPLE_W'($urandom);
      case ($urandom_range(0, 7))
        0: smp = 16'sh7fff;
        1: smp = 16'sh8000;
        2, 3: smp = SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
        default: begin
        end
      endcase
      sample_q.push_back(smp);
    end
  endtask

  // sender: bursts of requests separated by random gaps, payload held while stalled
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_sample(in_sample);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid  <= 1'b1;
          in_sample <= sample_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern redrawn periodically at random, sometimes none at all
  int          stall_cycle   = 0;
  logic [15:0] stall_pattern = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      stall_cycle   = 0;
      stall_pattern = '0;
    end else begin
      if (stall_cycle % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '0;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom & $urandom);
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
      end
      out_stall <= stall_pattern[stall_cycle % 16];
      stall_cycle++;
    end
  end

  // monitor: each accepted result against the oldest expected bit
  bit_result_t got_bit;
  bit_result_t want_bit;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_bit = '{out_delta_bit, out_decoded_level, out_code_byte, out_byte_ready, out_last};
      if (expected_bits.size() == 0) begin
        note_failure($sformatf("unexpected result bit=%0d level=%0d byte=%02h ready=%0d last=%0d",
                               got_bit.delta_bit, got_bit.decoded_level, got_bit.code_byte,
                               got_bit.byte_ready, got_bit.last));
      end else begin
        want_bit = expected_bits.pop_front();
        bits_checked++;
        if (got_bit.delta_bit !== want_bit.delta_bit ||
            got_bit.decoded_level !== want_bit.decoded_level ||
            got_bit.code_byte !== want_bit.code_byte ||
            got_bit.byte_ready !== want_bit.byte_ready ||
            got_bit.last !== want_bit.last) begin
          note_failure($sformatf({"result %0d: expected bit=%0d level=%0d byte=%02h ready=%0d ",
                                  "last=%0d, got bit=%0d level=%0d byte=%02h ready=%0d last=%0d"},
                                 bits_checked, want_bit.delta_bit, want_bit.decoded_level,
                                 want_bit.code_byte, want_bit.byte_ready, want_bit.last,
                                 got_bit.delta_bit, got_bit.decoded_level, got_bit.code_byte,
                                 got_bit.byte_ready, got_bit.last));
        end
      end
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", expected_bits.size());
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus sequence
  logic [CDATA_W-1:0] pct_data;
  logic [CDATA_W-1:0] amp_data;

  initial begin
    @(posedge rst_n);
    @(posedge clk);

    // fastest rate, largest scale: climb to top saturation then fall to bottom
    write_reg(REG_OVERSAMPLE, 10'd1000);
    write_reg(REG_AMPLITUDE, 10'd40);
    cfg_valid <= 1'b0;
    settings_used++;
    @(negedge clk);
    repeat (4) sample_q.push_back(16'sh7fff);
    repeat (7) sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh0000);
    sample_q.push_back(16'shffff);
    sample_q.push_back(16'sh0001);
    wait_idle();

    // out of range values saturate, spare indexes are ignored
    write_reg(REG_OVERSAMPLE, 10'd0);
    write_reg(REG_AMPLITUDE, 10'd1);
    write_reg(REG_SPARE_A, 10'd1023);
    write_reg(REG_SPARE_B, 10'd5);
    cfg_valid <= 1'b0;
    settings_used++;
    @(negedge clk);
    // extremes and rounding edges at the smallest scale
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh2000);
    sample_q.push_back(-16'sh2000);
    sample_q.push_back(-16'sh2001);
    sample_q.push_back(16'sh0000);
    wait_idle();

    // random settings, state carried across each change
    for (int ph = 0; ph < 5; ph++) begin
      pct_data = CDATA_W'($urandom_range(0, 1) ? pct_edges[$urandom_range(0, 9)]
                                               : $urandom_range(0, 1023));
      amp_data = CDATA_W'($urandom_range(0, 1) ? amp_edges[$urandom_range(0, 9)]
                                               : $urandom_range(0, 1023));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_OVERSAMPLE, pct_data);
        write_reg(REG_AMPLITUDE, amp_data);
      end else begin
        write_reg(REG_AMPLITUDE, amp_data);
        write_reg(REG_OVERSAMPLE, pct_data);
      end
      if ($urandom_range(0, 1))
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CDATA_W'($urandom_range(0, 1023)));
      cfg_valid <= 1'b0;
      settings_used++;
      @(negedge clk);
      queue_random_samples(11);
      // sender holds off until the block has drained
      if (ph == 2) begin
        wait_idle();
        @(negedge clk);
      end
      queue_random_samples(11);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bits.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_bits.size()));

    $display("covered %0d samples and %0d delta bits over %0d settings, %0d register writes",
             samples_sent, bits_checked, settings_used, reg_writes);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
